// File: rtl/fwpid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwpid_pkg
// Shared widths, register indexes, state codes and types for the four wheel
// pid speed loop.
// ----------------------------------------------------------------------------
package fwpid_pkg;

    // lane count, fixed by the four named wheel ports
    localparam int WHEELS = 4;

    // field widths
    localparam int CNT_W   = 16;
    localparam int TGT_W   = 8;
    localparam int DRV_W   = 16;
    localparam int GAIN_W  = 16;
    localparam int SCALE_W = 10;
    localparam int LIM_W   = 15;

    // internal arithmetic widths
    localparam int TSC_W  = TGT_W + SCALE_W + 1;   // target times scale
    localparam int ERR_W  = 25;                    // error, 1/256 count
    localparam int ACC_W  = 25;                    // integral, 1/256 count
    localparam int LAST_W = 26;                    // previous error / difference
    localparam int PROD_W = GAIN_W + 1 + LAST_W;   // one gain product
    localparam int SUM_W  = PROD_W + 2;            // sum of three products
    localparam int CLP_W  = LIM_W + 17;            // clamped sum, 1/65536 units

    // target saturation bound
    localparam logic signed [TGT_W-1:0] TGT_MAX = 8'sd100;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_MASK = 3'd6;
    localparam int CFG_DATA_W = 16;

    // reset values of the registers
    localparam logic [GAIN_W-1:0]  RST_PROP_GAIN   = 16'd128;
    localparam logic [GAIN_W-1:0]  RST_INTEG_GAIN  = 16'd77;
    localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN  = 16'd0;
    localparam logic [SCALE_W-1:0] RST_SPEED_SCALE = 10'd384;
    localparam logic [LIM_W-1:0]   RST_INTEG_LIMIT = 15'd1000;
    localparam logic [LIM_W-1:0]   RST_OUTPUT_LIMIT = 15'd100;
    localparam logic [WHEELS-1:0]  RST_INVERT_MASK = '0;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INTEG,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_OUT
    } t_state;

    // shared gains, speed scale and limits
    typedef struct packed {
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integ_gain;
        logic [GAIN_W-1:0]  deriv_gain;
        logic [SCALE_W-1:0] speed_scale;
        logic [LIM_W-1:0]   integral_limit;
        logic [LIM_W-1:0]   output_limit;
    } t_cfg;

    // per-step strobes from the sequencer to every lane
    typedef struct packed {
        logic load;
        logic integ;
        logic mul_p;
        logic mul_i;
        logic mul_d;
    } t_lane_ctl;

    typedef logic signed [DRV_W-1:0] t_drive;
    typedef logic signed [CNT_W-1:0] t_count;
    typedef logic signed [TGT_W-1:0] t_target;

endpackage

// File: rtl/fwpid_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwpid_lane
// One wheel's pid core: error, clamped integral, three gain products summed
// through one shared multiplier, then output clamp and truncation.
// ----------------------------------------------------------------------------
module fwpid_lane (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fwpid_pkg::t_lane_ctl i_ctl,
    input  fwpid_pkg::t_cfg      i_cfg,
    input  logic                 i_invert,
    input  fwpid_pkg::t_count    i_count,
    input  fwpid_pkg::t_target   i_target,
    output fwpid_pkg::t_drive    o_drive
);

    // wheel state
    logic signed [fwpid_pkg::ACC_W-1:0]  r_integ;
    logic signed [fwpid_pkg::LAST_W-1:0] r_last;

    // working registers
    logic signed [fwpid_pkg::ERR_W-1:0]  r_err;
    logic                                r_zero;
    logic signed [fwpid_pkg::ACC_W-1:0]  r_acc;
    logic signed [fwpid_pkg::LAST_W-1:0] r_diff;
    logic signed [fwpid_pkg::SUM_W-1:0]  r_sum;

    logic signed [fwpid_pkg::CNT_W-1:0]  w_cnt;
    logic signed [fwpid_pkg::TGT_W-1:0]  w_tgt;
    logic signed [fwpid_pkg::TSC_W-1:0]  w_tgt_scaled;
    logic signed [fwpid_pkg::ERR_W-1:0]  w_err;

    logic signed [fwpid_pkg::LAST_W-1:0] w_acc_sum;
    logic signed [fwpid_pkg::LAST_W-1:0] w_ilim;
    logic signed [fwpid_pkg::ACC_W-1:0]  w_acc;
    logic signed [fwpid_pkg::LAST_W-1:0] w_diff;

    logic [fwpid_pkg::GAIN_W-1:0]        w_gain;
    logic signed [fwpid_pkg::LAST_W-1:0] w_opnd;
    logic signed [fwpid_pkg::PROD_W-1:0] w_prod;

    logic signed [fwpid_pkg::CLP_W-1:0]  w_olim;
    logic signed [fwpid_pkg::CLP_W-1:0]  w_sum_clp;
    logic signed [fwpid_pkg::CLP_W-1:0]  w_mag;
    logic signed [fwpid_pkg::DRV_W-1:0]  w_quot;
    logic signed [fwpid_pkg::DRV_W-1:0]  w_drive;

    // error from the incoming request: saturate target, invert count
    always_comb begin
        w_cnt = i_invert ? -i_count : i_count;
        if (i_target > fwpid_pkg::TGT_MAX) begin
            w_tgt = fwpid_pkg::TGT_MAX;
        end else if (i_target < -fwpid_pkg::TGT_MAX) begin
            w_tgt = -fwpid_pkg::TGT_MAX;
        end else begin
            w_tgt = i_target;
        end
        w_tgt_scaled = w_tgt * $signed({1'b0, i_cfg.speed_scale});
        w_err = fwpid_pkg::ERR_W'(w_tgt_scaled)
              - (fwpid_pkg::ERR_W'(w_cnt) <<< 8);
    end

    // integral with symmetric clamp, error difference
    always_comb begin
        w_acc_sum = fwpid_pkg::LAST_W'(r_integ) + fwpid_pkg::LAST_W'(r_err);
        w_ilim    = $signed({3'b000, i_cfg.integral_limit, 8'h00});
        if (w_acc_sum > w_ilim) begin
            w_acc = fwpid_pkg::ACC_W'(w_ilim);
        end else if (w_acc_sum < -w_ilim) begin
            w_acc = fwpid_pkg::ACC_W'(-w_ilim);
        end else begin
            w_acc = fwpid_pkg::ACC_W'(w_acc_sum);
        end
        w_diff = fwpid_pkg::LAST_W'(r_err) - r_last;
    end

    // shared multiplier operand selection
    always_comb begin
        priority if (i_ctl.mul_p) begin
            w_gain = i_cfg.prop_gain;
            w_opnd = fwpid_pkg::LAST_W'(r_err);
        end else if (i_ctl.mul_i) begin
            w_gain = i_cfg.integ_gain;
            w_opnd = fwpid_pkg::LAST_W'(r_acc);
        end else begin
            w_gain = i_cfg.deriv_gain;
            w_opnd = r_diff;
        end
        w_prod = $signed({1'b0, w_gain}) * w_opnd;
    end

    // output clamp and truncation toward zero
    always_comb begin
        w_olim = $signed({1'b0, i_cfg.output_limit, 16'h0000});
        if (r_sum > fwpid_pkg::SUM_W'(w_olim)) begin
            w_sum_clp = w_olim;
        end else if (r_sum < -fwpid_pkg::SUM_W'(w_olim)) begin
            w_sum_clp = -w_olim;
        end else begin
            w_sum_clp = fwpid_pkg::CLP_W'(r_sum);
        end
        w_mag   = w_sum_clp[fwpid_pkg::CLP_W-1] ? -w_sum_clp : w_sum_clp;
        w_quot  = $signed(w_mag[fwpid_pkg::CLP_W-1 -: fwpid_pkg::DRV_W]);
        w_drive = w_sum_clp[fwpid_pkg::CLP_W-1] ? -w_quot : w_quot;
    end

    assign o_drive = r_zero ? '0 : w_drive;

    // wheel state update, cleared by a zero target
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_last  <= '0;
        end else if (i_ctl.integ) begin
            if (r_zero) begin
                r_integ <= '0;
                r_last  <= '0;
            end else begin
                r_integ <= w_acc;
                r_last  <= fwpid_pkg::LAST_W'(r_err);
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_err  <= w_err;
            r_zero <= (w_tgt == '0);
        end
        if (i_ctl.integ) begin
            r_acc  <= w_acc;
            r_diff <= w_diff;
        end
        if (i_ctl.mul_p) begin
            r_sum <= fwpid_pkg::SUM_W'(w_prod);
        end else if (i_ctl.mul_i || i_ctl.mul_d) begin
            r_sum <= r_sum + fwpid_pkg::SUM_W'(w_prod);
        end
    end

endmodule

// File: rtl/fwpid_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwpid_merge
// Gathers the lane drive values into one result register and holds it
// until the downstream side takes the result.
// ----------------------------------------------------------------------------
module fwpid_merge (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  fwpid_pkg::t_drive i_drive [fwpid_pkg::WHEELS],
    input  logic              i_stall,
    output logic              o_free,
    output logic              o_valid,
    output fwpid_pkg::t_drive o_drive [fwpid_pkg::WHEELS]
);

    logic              r_valid;
    fwpid_pkg::t_drive r_drive [fwpid_pkg::WHEELS];

    // register can take a new result when empty or being emptied
    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int w = 0; w < fwpid_pkg::WHEELS; w++) begin
                r_drive[w] <= i_drive[w];
            end
        end
    end

    always_comb begin
        for (int w = 0; w < fwpid_pkg::WHEELS; w++) begin
            o_drive[w] = r_drive[w];
        end
    end

endmodule

// File: rtl/four_wheel_pid_speed_loop.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_wheel_pid_speed_loop
// Four-lane fixed-point pid speed loop with integral clamp and shared gains.
//
//   channel   direction  handshake                 payload
//   input     in         i_in_valid / o_in_stall   i_count_*, i_target_*
//   output    out        o_out_valid / i_out_stall o_drive_*
//   config    in         i_cfg_we (no handshake)   i_cfg_idx, i_cfg_data
//
// The error is formed on the accept edge, then come one integral step, three
// passes through each lane's single multiplier, and the output clamp into
// the result register, which is loaded once it is free. The sequencer
// returns to idle as the result is loaded and only then takes the next
// request, so a new request is not taken before the last result is loaded.
// A stalled result holds the sequencer in its last step only.
// Reset is synchronous, active low, and clears the integrals and previous errors.
// ----------------------------------------------------------------------------
module four_wheel_pid_speed_loop (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [fwpid_pkg::CNT_W-1:0]   i_count_front_left,
    input  logic signed [fwpid_pkg::CNT_W-1:0]   i_count_front_right,
    input  logic signed [fwpid_pkg::CNT_W-1:0]   i_count_rear_left,
    input  logic signed [fwpid_pkg::CNT_W-1:0]   i_count_rear_right,
    input  logic signed [fwpid_pkg::TGT_W-1:0]   i_target_front_left,
    input  logic signed [fwpid_pkg::TGT_W-1:0]   i_target_front_right,
    input  logic signed [fwpid_pkg::TGT_W-1:0]   i_target_rear_left,
    input  logic signed [fwpid_pkg::TGT_W-1:0]   i_target_rear_right,
    // output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [fwpid_pkg::DRV_W-1:0]   o_drive_front_left,
    output logic signed [fwpid_pkg::DRV_W-1:0]   o_drive_front_right,
    output logic signed [fwpid_pkg::DRV_W-1:0]   o_drive_rear_left,
    output logic signed [fwpid_pkg::DRV_W-1:0]   o_drive_rear_right,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [fwpid_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [fwpid_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    fwpid_pkg::t_state    r_state;
    fwpid_pkg::t_state    n_state;
    fwpid_pkg::t_cfg      r_cfg;
    logic [fwpid_pkg::WHEELS-1:0] r_invert_mask;
    fwpid_pkg::t_lane_ctl w_ctl;
    logic                 w_accept;
    logic                 w_merge_free;
    logic                 w_merge_load;

    fwpid_pkg::t_count    w_count [fwpid_pkg::WHEELS];
    fwpid_pkg::t_target   w_target [fwpid_pkg::WHEELS];
    fwpid_pkg::t_drive    w_lane_drive [fwpid_pkg::WHEELS];
    fwpid_pkg::t_drive    w_out_drive [fwpid_pkg::WHEELS];

    // wheel ports into lane order
    assign w_count[0]  = i_count_front_left;
    assign w_count[1]  = i_count_front_right;
    assign w_count[2]  = i_count_rear_left;
    assign w_count[3]  = i_count_rear_right;
    assign w_target[0] = i_target_front_left;
    assign w_target[1] = i_target_front_right;
    assign w_target[2] = i_target_rear_left;
    assign w_target[3] = i_target_rear_right;

    assign o_drive_front_left  = w_out_drive[0];
    assign o_drive_front_right = w_out_drive[1];
    assign o_drive_rear_left   = w_out_drive[2];
    assign o_drive_rear_right  = w_out_drive[3];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain      <= fwpid_pkg::RST_PROP_GAIN;
            r_cfg.integ_gain     <= fwpid_pkg::RST_INTEG_GAIN;
            r_cfg.deriv_gain     <= fwpid_pkg::RST_DERIV_GAIN;
            r_cfg.speed_scale    <= fwpid_pkg::RST_SPEED_SCALE;
            r_cfg.integral_limit <= fwpid_pkg::RST_INTEG_LIMIT;
            r_cfg.output_limit   <= fwpid_pkg::RST_OUTPUT_LIMIT;
            r_invert_mask        <= fwpid_pkg::RST_INVERT_MASK;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fwpid_pkg::CFG_PROP_GAIN: begin
                    r_cfg.prop_gain <= i_cfg_data[fwpid_pkg::GAIN_W-1:0];
                end
                fwpid_pkg::CFG_INTEG_GAIN: begin
                    r_cfg.integ_gain <= i_cfg_data[fwpid_pkg::GAIN_W-1:0];
                end
                fwpid_pkg::CFG_DERIV_GAIN: begin
                    r_cfg.deriv_gain <= i_cfg_data[fwpid_pkg::GAIN_W-1:0];
                end
                fwpid_pkg::CFG_SPEED_SCALE: begin
                    r_cfg.speed_scale <= i_cfg_data[fwpid_pkg::SCALE_W-1:0];
                end
                fwpid_pkg::CFG_INTEG_LIMIT: begin
                    r_cfg.integral_limit <= i_cfg_data[fwpid_pkg::LIM_W-1:0];
                end
                fwpid_pkg::CFG_OUTPUT_LIMIT: begin
                    r_cfg.output_limit <= i_cfg_data[fwpid_pkg::LIM_W-1:0];
                end
                fwpid_pkg::CFG_INVERT_MASK: begin
                    r_invert_mask <= i_cfg_data[fwpid_pkg::WHEELS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fwpid_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fwpid_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = fwpid_pkg::ST_INTEG;
                end
            end
            fwpid_pkg::ST_INTEG: n_state = fwpid_pkg::ST_MUL_P;
            fwpid_pkg::ST_MUL_P: n_state = fwpid_pkg::ST_MUL_I;
            fwpid_pkg::ST_MUL_I: n_state = fwpid_pkg::ST_MUL_D;
            fwpid_pkg::ST_MUL_D: n_state = fwpid_pkg::ST_OUT;
            fwpid_pkg::ST_OUT: begin
                if (w_merge_free) begin
                    n_state = fwpid_pkg::ST_IDLE;
                end
            end
            default: n_state = fwpid_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_stall   = (r_state != fwpid_pkg::ST_IDLE);
        w_accept     = i_in_valid && (r_state == fwpid_pkg::ST_IDLE);
        w_ctl.load   = w_accept;
        w_ctl.integ  = (r_state == fwpid_pkg::ST_INTEG);
        w_ctl.mul_p  = (r_state == fwpid_pkg::ST_MUL_P);
        w_ctl.mul_i  = (r_state == fwpid_pkg::ST_MUL_I);
        w_ctl.mul_d  = (r_state == fwpid_pkg::ST_MUL_D);
        w_merge_load = (r_state == fwpid_pkg::ST_OUT) && w_merge_free;
    end

    // one pid lane per wheel
    for (genvar g = 0; g < fwpid_pkg::WHEELS; g++) begin : g_lane
        fwpid_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_cfg    (r_cfg),
            .i_invert (r_invert_mask[g]),
            .i_count  (w_count[g]),
            .i_target (w_target[g]),
            .o_drive  (w_lane_drive[g])
        );
    end

    // result register
    fwpid_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_merge_load),
        .i_drive (w_lane_drive),
        .i_stall (i_out_stall),
        .o_free  (w_merge_free),
        .o_valid (o_out_valid),
        .o_drive (w_out_drive)
    );

    // an accepted request always starts the integral step
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == fwpid_pkg::ST_INTEG))
        else $error("accepted request did not start the integral step");

    // a new result only appears out of the final step
    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == fwpid_pkg::ST_OUT))
        else $error("result appeared outside the output step");

    // a held result keeps the sequencer waiting in its final step
    a_hold_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fwpid_pkg::ST_OUT && o_out_valid && i_out_stall)
        |=> (r_state == fwpid_pkg::ST_OUT))
        else $error("sequencer left the output step while the result was held");

endmodule
